@@ src/lcdts_pkg.sv @@
// Shared types and constants for the LCD mode timing sequencer.
// No dependencies; every other file imports this package.
`default_nettype none

package lcdts_pkg;

   localparam int unsigned LINE_W  = 8;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned DELTA_W = 8;
   localparam int unsigned IRQ_W   = 4;

   localparam int unsigned VISIBLE_LINES_DEF = 144;
   localparam int unsigned LAST_LINE_DEF     = 153;

   localparam logic [COUNT_W-1:0] OAM_CYCLES    = COUNT_W'(80);
   localparam logic [COUNT_W-1:0] VRAM_CYCLES   = COUNT_W'(172);
   localparam logic [COUNT_W-1:0] HBLANK_CYCLES = COUNT_W'(204);
   localparam logic [COUNT_W-1:0] LINE_CYCLES   = COUNT_W'(456);
   localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};

   // Bit positions in irq_enables
   localparam int unsigned IRQ_LYC_BIT    = 3;
   localparam int unsigned IRQ_OAM_BIT    = 2;
   localparam int unsigned IRQ_VBLANK_BIT = 1;
   localparam int unsigned IRQ_HBLANK_BIT = 0;

   typedef enum logic [1:0] {
      PHASE_HBLANK = 2'd0,
      PHASE_VBLANK = 2'd1,
      PHASE_OAM    = 2'd2,
      PHASE_VRAM   = 2'd3
   } phase_type;

   typedef struct packed {
      logic [DELTA_W-1:0] delta_cycles;
      logic [LINE_W-1:0]  line_compare;
      logic [IRQ_W-1:0]   irq_enables;
   } req_type;

   typedef struct packed {
      logic [1:0]        lcd_mode;
      logic [LINE_W-1:0] line_number;
      logic              coincidence;
      logic              stat_request;
      logic              vblank_request;
      logic              line_done;
      logic              frame_done;
   } rsp_type;

   // Staged tick handed from the input register to the sequencer
   typedef struct packed {
      logic    valid;
      req_type item;
   } step_type;

endpackage

`default_nettype wire

@@ src/lcdts_in_stage.sv @@
// Input register of the tick channel: holds one tick until the sequencer takes it.
// Depends on lcdts_pkg.
`default_nettype none

module lcdts_in_stage
   import lcdts_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire req_type  req_data,
   input  wire logic     advance,
   output step_type      step
);

   logic    valid_ff, valid_in;
   req_type item_ff, item_in;
   logic    take;

   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = take ? 1'b1 : (advance ? 1'b0 : valid_ff);
      item_in  = take ? req_data : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign step.valid = valid_ff;
   assign step.item  = item_ff;

endmodule

`default_nettype wire

@@ src/lcdts_sequencer.sv @@
// Mode sequencer: cycle counter, phase, line and held status, updated once per tick.
// Depends on lcdts_pkg.
`default_nettype none

module lcdts_sequencer
   import lcdts_pkg::*;
#(
   parameter int unsigned VISIBLE_LINES = VISIBLE_LINES_DEF,
   parameter int unsigned LAST_LINE     = LAST_LINE_DEF
)(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     lcd_enable,
   input  wire step_type step,
   input  wire logic     advance,
   output rsp_type       result
);

   logic [COUNT_W-1:0] count_ff, count_in;
   phase_type          phase_ff, phase_in;
   logic [LINE_W-1:0]  line_ff, line_in;
   logic               coin_ff, coin_in;
   logic               stat_ff, stat_in;
   logic               vbl_ff, vbl_in;

   logic [COUNT_W:0]   sum;
   logic [COUNT_W-1:0] sat;
   logic [LINE_W:0]    line_next;
   logic               refresh;
   logic               line_pulse;
   logic               frame_pulse;
   logic               match;
   logic               req;

   // Next state
   always_comb begin
      sum         = {1'b0, count_ff} + (COUNT_W+1)'(step.item.delta_cycles);
      sat         = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
      line_next   = {1'b0, line_ff} + (LINE_W+1)'(1);
      phase_in    = phase_ff;
      count_in    = sat;
      line_in     = line_ff;
      refresh     = 1'b0;
      line_pulse  = 1'b0;
      frame_pulse = 1'b0;
      if (lcd_enable) begin
         case (phase_ff)
            PHASE_OAM: begin
               refresh = 1'b1;
               if (sat >= OAM_CYCLES) begin
                  phase_in = PHASE_VRAM;
                  count_in = sat - OAM_CYCLES;
               end
            end
            PHASE_VRAM: begin
               refresh = 1'b1;
               if (sat >= VRAM_CYCLES) begin
                  phase_in   = PHASE_HBLANK;
                  count_in   = sat - VRAM_CYCLES;
                  line_pulse = 1'b1;
               end
            end
            PHASE_HBLANK: begin
               if (sat >= HBLANK_CYCLES) begin
                  refresh  = 1'b1;
                  count_in = sat - HBLANK_CYCLES;
                  line_in  = line_next[LINE_W-1:0];
                  if (line_next[LINE_W-1:0] == LINE_W'(VISIBLE_LINES)) begin
                     phase_in    = PHASE_VBLANK;
                     frame_pulse = 1'b1;
                  end else begin
                     phase_in = PHASE_OAM;
                  end
               end
            end
            PHASE_VBLANK: begin
               if (sat >= LINE_CYCLES) begin
                  refresh  = 1'b1;
                  count_in = sat - LINE_CYCLES;
                  // wrap to the top of the frame once past the last line
                  if (line_next > (LINE_W+1)'(LAST_LINE)) begin
                     phase_in = PHASE_OAM;
                     line_in  = '0;
                  end else begin
                     line_in = line_next[LINE_W-1:0];
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Held status, taken from the updated phase and line
   always_comb begin
      match = (step.item.line_compare == line_in);
      req   = (step.item.irq_enables[IRQ_LYC_BIT] && match)
           || (step.item.irq_enables[IRQ_OAM_BIT] && phase_in == PHASE_OAM)
           || (step.item.irq_enables[IRQ_VBLANK_BIT] && phase_in == PHASE_VBLANK)
           || (step.item.irq_enables[IRQ_HBLANK_BIT] && phase_in == PHASE_HBLANK);
      coin_in = refresh ? match : coin_ff;
      stat_in = refresh ? req : stat_ff;
      vbl_in  = refresh ? (phase_in == PHASE_VBLANK) : vbl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         phase_ff <= PHASE_OAM;
         line_ff  <= '0;
         coin_ff  <= 1'b0;
         stat_ff  <= 1'b0;
         vbl_ff   <= 1'b0;
      end else if (advance) begin
         count_ff <= count_in;
         phase_ff <= phase_in;
         line_ff  <= line_in;
         coin_ff  <= coin_in;
         stat_ff  <= stat_in;
         vbl_ff   <= vbl_in;
      end
   end

   always_comb begin
      result.lcd_mode       = phase_in;
      result.line_number    = line_in;
      result.coincidence    = coin_in;
      result.stat_request   = stat_in;
      result.vblank_request = vbl_in;
      result.line_done      = line_pulse;
      result.frame_done     = frame_pulse;
   end

endmodule

`default_nettype wire

@@ src/lcdts_out_stage.sv @@
// Result register of the status channel: holds one result until it is taken.
// Depends on lcdts_pkg.
`default_nettype none

module lcdts_out_stage
   import lcdts_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    advance,
   input  wire rsp_type result,
   output logic         out_free,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
      data_in  = advance ? result : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

@@ src/lcd_mode_timing_sequencer_top.sv @@
// Channel  Ports                           Direction  Moves
// req      req_valid/req_ready/req_data    in         one tick per transfer
// rsp      rsp_valid/rsp_ready/rsp_data    out        one status result per tick
// csr      csr_valid/csr_ready/csr_data    in         lcd_enable write
//
// One tick is accepted per cycle while the input register is empty or moving on. The
// input register holds it until the result register has room; the sequencer logic then
// loads its result into the result register, from which the result can transfer.
// Reset (synchronous) puts the sequencer in OAM scan at line 0 with the counter clear.
// A stalled result holds the result register and the staged tick in the same cycle;
// the input takes one more tick only while its register is empty.
// csr_ready is always high; write it only while no tick is in flight.
// Depends on lcdts_pkg, lcdts_in_stage, lcdts_sequencer, lcdts_out_stage.
`default_nettype none

module lcd_mode_timing_sequencer_top
   import lcdts_pkg::*;
#(
   parameter int unsigned VISIBLE_LINES = VISIBLE_LINES_DEF,
   parameter int unsigned LAST_LINE     = LAST_LINE_DEF
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_data
);

   logic     enable_ff, enable_in;
   step_type step;
   rsp_type  result;
   logic     out_free;
   logic     advance;

   assign csr_ready = 1'b1;
   assign enable_in = (csr_valid && csr_ready) ? csr_data : enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
      end
   end

   // move a staged tick into the result register when it has room
   assign advance = step.valid && out_free;

   lcdts_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .advance   (advance),
      .step      (step)
   );

   lcdts_sequencer #(
      .VISIBLE_LINES (VISIBLE_LINES),
      .LAST_LINE     (LAST_LINE)
   ) u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .lcd_enable (enable_ff),
      .step       (step),
      .advance    (advance),
      .result     (result)
   );

   lcdts_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_line_done_hblank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.line_done) |-> (rsp_data.lcd_mode == PHASE_HBLANK))
      else $error("line_done outside hblank");

   a_frame_done_vblank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_done) |-> (rsp_data.lcd_mode == PHASE_VBLANK
         && rsp_data.vblank_request))
      else $error("frame_done without vblank entry");

   a_pulses_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.line_done && rsp_data.frame_done))
      else $error("line_done and frame_done together");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without output backpressure");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for lcd_mode_timing_sequencer_top: ticks drive a line-timing tracker
// whose predicted status is compared against every result transfer.
// Depends on lcdts_pkg and the RTL under src.
`timescale 1ns / 1ps

module tb;
   import lcdts_pkg::*;

   // Tracks counter, mode, line and held status, and queues the status each tick should produce
   class lcd_timing_tracker;
      rsp_type              expected_status[$];
      logic [COUNT_W-1:0]   count;
      phase_type            phase;
      logic [LINE_W-1:0]    line;
      logic                 coinc;
      logic                 stat_req;
      logic                 vblank_req;
      logic                 enable;
      int                   mismatches;

      function new();
         count      = '0;
         phase      = PHASE_OAM;
         line       = '0;
         coinc      = 1'b0;
         stat_req   = 1'b0;
         vblank_req = 1'b0;
         enable     = 1'b0;
         mismatches = 0;
      endfunction

      function void set_enable(logic value);
         enable = value;
      endfunction

      function void refresh(logic [LINE_W-1:0] lyc, logic [IRQ_W-1:0] en);
         coinc      = (lyc == line);
         stat_req   = (en[IRQ_LYC_BIT] && coinc) ||
                      (en[IRQ_OAM_BIT] && phase == PHASE_OAM) ||
                      (en[IRQ_VBLANK_BIT] && phase == PHASE_VBLANK) ||
                      (en[IRQ_HBLANK_BIT] && phase == PHASE_HBLANK);
         vblank_req = (phase == PHASE_VBLANK);
      endfunction

      function void note_tick(req_type t);
         logic [COUNT_W:0] sum;
         logic [LINE_W:0]  next_line;
         rsp_type          r;
         sum   = {1'b0, count} + (COUNT_W+1)'(t.delta_cycles);
         count = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
         r.line_done  = 1'b0;
         r.frame_done = 1'b0;
         if (enable) begin
            case (phase)
               PHASE_OAM: begin
                  if (count >= OAM_CYCLES) begin
                     phase = PHASE_VRAM;
                     count = count - OAM_CYCLES;
                  end
                  refresh(t.line_compare, t.irq_enables);
               end
               PHASE_VRAM: begin
                  if (count >= VRAM_CYCLES) begin
                     phase = PHASE_HBLANK;
                     count = count - VRAM_CYCLES;
                     r.line_done = 1'b1;
                  end
                  refresh(t.line_compare, t.irq_enables);
               end
               PHASE_HBLANK: begin
                  if (count >= HBLANK_CYCLES) begin
                     count = count - HBLANK_CYCLES;
                     line  = line + 1'b1;
                     if (line == LINE_W'(VISIBLE_LINES_DEF)) begin
                        phase        = PHASE_VBLANK;
                        r.frame_done = 1'b1;
                     end else begin
                        phase = PHASE_OAM;
                     end
                     refresh(t.line_compare, t.irq_enables);
                  end
               end
               default: begin
                  if (count >= LINE_CYCLES) begin
                     count     = count - LINE_CYCLES;
                     next_line = {1'b0, line} + (LINE_W+1)'(1);
                     // wrap to the top of the frame once past the last line
                     if (next_line > (LINE_W+1)'(LAST_LINE_DEF)) begin
                        phase     = PHASE_OAM;
                        next_line = '0;
                     end
                     line = next_line[LINE_W-1:0];
                     refresh(t.line_compare, t.irq_enables);
                  end
               end
            endcase
         end
         r.lcd_mode       = phase;
         r.line_number    = line;
         r.coincidence    = coinc;
         r.stat_request   = stat_req;
         r.vblank_request = vblank_req;
         expected_status.push_back(r);
      endfunction

      function void check_status(rsp_type got);
         rsp_type want;
         if (expected_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result with nothing pending: mode %0d line %0d", got.lcd_mode,
                        got.line_number);
            return;
         end
         want = expected_status.pop_front();
         if (got.lcd_mode !== want.lcd_mode || got.line_number !== want.line_number ||
             got.coincidence !== want.coincidence || got.stat_request !== want.stat_request ||
             got.vblank_request !== want.vblank_request || got.line_done !== want.line_done ||
             got.frame_done !== want.frame_done) begin
            mismatches++;
            if (mismatches <= 10) begin
               $write("status mismatch (exp/got): mode %0d/%0d line %0d/%0d lyc %0b/%0b ",
                      want.lcd_mode, got.lcd_mode, want.line_number, got.line_number,
                      want.coincidence, got.coincidence);
               $display("stat %0b/%0b vbl %0b/%0b line_done %0b/%0b frame_done %0b/%0b",
                        want.stat_request, got.stat_request, want.vblank_request,
                        got.vblank_request, want.line_done, got.line_done,
                        want.frame_done, got.frame_done);
            end
         end
      endfunction
   endclass

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data  = 1'b0;
   logic    steady    = 1'b0;

   lcd_timing_tracker timing;

   lcd_mode_timing_sequencer_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 34);
   end

   // Record every transfer at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) timing.note_tick(req_data);
         if (rsp_valid && rsp_ready) timing.check_status(rsp_data);
         if (csr_valid && csr_ready) timing.set_enable(csr_data);
      end
   end

   function automatic req_type tick_of(logic [7:0] d, logic [7:0] lyc, logic [3:0] en);
      req_type t;
      t.delta_cycles = d;
      t.line_compare = lyc;
      t.irq_enables  = en;
      return t;
   endfunction

   // Bias the compare value toward the tracked line so coincidence shows up often
   function automatic req_type random_tick(int unsigned lo, int unsigned hi);
      req_type     t;
      int unsigned pick;
      pick = $urandom_range(99);
      if ($urandom_range(99) < 20) t.delta_cycles = 8'($urandom_range(255));
      else t.delta_cycles = 8'($urandom_range(hi, lo));
      if (pick < 40) t.line_compare = timing.line;
      else if (pick < 55) t.line_compare = timing.line + 8'd1;
      else t.line_compare = 8'($urandom_range(255));
      t.irq_enables = 4'($urandom_range(15));
      return t;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer
   task automatic send_tick(input req_type t);
      while (!steady && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (timing.expected_status.size() != 0) @(negedge clock);
   endtask

   task automatic write_enable(input logic value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      timing = new();
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // display off after reset: only the counter moves
      send_tick(tick_of(8'd255, 8'd0, 4'd15));
      send_tick(tick_of(8'd0, 8'd255, 4'd0));
      send_tick(tick_of(8'd255, 8'd153, 4'd8));
      send_tick(tick_of(8'd1, 8'd0, 4'd4));
      settle();
      write_enable(1'b1);

      send_tick(tick_of(8'd0, 8'd0, 4'd8));
      send_tick(tick_of(8'd0, 8'd0, 4'd4));
      send_tick(tick_of(8'd0, 8'd255, 4'd2));
      send_tick(tick_of(8'd255, 8'd1, 4'd1));
      send_tick(tick_of(8'd255, 8'd0, 4'd15));
      send_tick(tick_of(8'd0, 8'd144, 4'd0));
      send_tick(tick_of(8'd200, 8'd1, 4'd9));
      send_tick(tick_of(8'd255, 8'd1, 4'd6));
      send_tick(tick_of(8'd100, 8'd255, 4'd3));
      send_tick(tick_of(8'd255, 8'd2, 4'd12));
      send_tick(tick_of(8'd0, 8'd2, 4'd8));
      send_tick(tick_of(8'd80, 8'd2, 4'd4));
      send_tick(tick_of(8'd172, 8'd3, 4'd1));
      send_tick(tick_of(8'd204, 8'd3, 4'd2));
      send_tick(tick_of(8'd255, 8'd4, 4'd15));
      send_tick(tick_of(8'd1, 8'd255, 4'd0));

      // large steps: about one transition per tick, sweeping whole frames
      for (int i = 0; i < 750; i++) begin
         if (i == 300) steady <= 1'b1;
         else if (i == 600) steady <= 1'b0;
         send_tick(random_tick(120, 255));
      end

      // display off long enough to pin the counter at its ceiling
      settle();
      write_enable(1'b0);
      for (int i = 0; i < 330; i++) send_tick(random_tick(240, 255));

      // drain the saturated counter with small steps
      settle();
      write_enable(1'b1);
      for (int i = 0; i < 550; i++) send_tick(random_tick(0, 120));

      settle();
      write_enable(1'b0);
      for (int i = 0; i < 40; i++) send_tick(random_tick(0, 255));

      settle();
      write_enable(1'b1);
      for (int i = 0; i < 100; i++) send_tick(random_tick(60, 255));

      settle();
      repeat (10) @(negedge clock);
      if (timing.mismatches == 0 && timing.expected_status.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
